FILE: rtl/mou_pkg.sv
// Shared types and constants for the multiplicative order unit.
// No dependencies.
`default_nettype none
package mou_pkg;
  localparam int unsigned WordW  = 64;
  localparam int unsigned OrderW = 63;
  localparam int unsigned TdataInW  = 128;
  localparam int unsigned TdataOutW = 64;

  localparam logic [WordW-1:0] WordOne = WordW'(1);
  localparam logic [WordW-1:0] WordTwo = WordW'(2);
  // One shift-and-add step per multiplier bit.
  localparam logic [6:0] MulSteps = 7'd64;
  // 3^40 is the largest power of three that fits 64 bits.
  localparam logic [5:0] ThreeExpMax = 6'd40;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCAN3,
    CMD_SETUP,
    CMD_STORE_B,
    CMD_CAND2,
    CMD_CAND3_START,
    CMD_CAND3_STEP,
    CMD_POW_INIT,
    CMD_MUL_RX,
    CMD_MUL_XX,
    CMD_STORE_R,
    CMD_STORE_X,
    CMD_ACCEPT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic       factor3;
  } cmd_t;

  typedef struct packed {
    logic is_two;
    logic scan_hit;
    logic scan_last;
    logic mul_busy;
    logic ord_odd;
    logic c3_zero;
    logic cnt3_zero;
    logic e_zero;
    logic e_lsb;
    logic r_one;
  } status_t;
endpackage
`default_nettype wire

FILE: rtl/mou_datapath.sv
// Datapath: classification, totient, shift-and-add modular multiply and exponentiation.
// Depends on mou_pkg.
`default_nettype none
module mou_datapath
  import mou_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  input  wire logic [WordW-1:0]  base_in,
  input  wire logic [WordW-1:0]  mod_in,
  output status_t                status,
  output logic [OrderW-1:0]      order
);
  logic [WordW-1:0] m, base_raw, base_red, ord, cand, x, r, e;
  logic [WordW-1:0] pw3, pw3_prev;
  logic [5:0]       k3, c3, cnt3;
  logic             is_two, halved;
  logic [WordW-1:0] acc, mul_x, mul_y;
  logic [6:0]       mul_cnt;
  logic [WordW-1:0] acc_dbl, acc_sum;

  function automatic logic [WordW-1:0] add_mod(input logic [WordW-1:0] a,
      input logic [WordW-1:0] c, input logic [WordW-1:0] mm);
    logic [WordW-1:0] room;
    room = mm - c;
    return (a >= room) ? (a - room) : (a + c);
  endfunction

  always_comb begin
    acc_dbl = add_mod(acc, acc, m);
    acc_sum = mul_y[WordW-1] ? add_mod(acc_dbl, mul_x, m) : acc_dbl;
  end

  always_comb begin
    status.is_two    = is_two;
    status.scan_hit  = (pw3 == m) && (k3 != 6'd0);
    status.scan_last = (k3 == ThreeExpMax);
    status.mul_busy  = (mul_cnt != 7'd0);
    status.ord_odd   = ord[0];
    status.c3_zero   = (c3 == 6'd0);
    status.cnt3_zero = (cnt3 == 6'd0);
    status.e_zero    = (e == '0);
    status.e_lsb     = e[0];
    status.r_one     = (r == WordOne);
  end

  assign order = ord[OrderW-1:0];

  // The order is kept as (1 or 2) * 3^c3 once the factor two is done, so a
  // candidate divided by three is rebuilt by repeated tripling.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LOAD: begin
        m        <= mod_in;
        base_raw <= base_in;
        is_two   <= (mod_in >= 64'd2) && ((mod_in & (mod_in - 64'd1)) == '0);
        pw3      <= WordOne;
        pw3_prev <= WordOne;
        k3       <= 6'd0;
      end
      CMD_SCAN3: begin
        pw3_prev <= pw3;
        pw3      <= pw3 + (pw3 << 1);
        k3       <= k3 + 6'd1;
      end
      CMD_SETUP: begin
        // phi(2^j) = 2^(j-1) and phi(3^k) = 2 * 3^(k-1).
        ord    <= is_two ? (m >> 1) : (pw3_prev << 1);
        c3     <= is_two ? 6'd0 : (k3 - 6'd1);
        halved <= 1'b0;
      end
      CMD_STORE_B: base_red <= acc;
      CMD_CAND2: cand <= ord >> 1;
      CMD_CAND3_START: begin
        cand <= halved ? WordOne : WordTwo;
        cnt3 <= c3 - 6'd1;
      end
      CMD_CAND3_STEP: begin
        cand <= cand + (cand << 1);
        cnt3 <= cnt3 - 6'd1;
      end
      CMD_POW_INIT: begin
        e <= cand;
        r <= WordOne;
        x <= base_red;
      end
      CMD_STORE_R: begin
        r    <= acc;
        e[0] <= 1'b0;
      end
      CMD_STORE_X: begin
        x <= acc;
        e <= e >> 1;
      end
      CMD_ACCEPT: begin
        ord <= cand;
        if (cmd.factor3) c3 <= c3 - 6'd1;
        else halved <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Shift-and-add multiplier; the base is reduced as 1 * base modulo m.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_cnt <= 7'd0;
    end else begin
      unique case (cmd.op)
        CMD_SETUP: begin
          mul_x <= WordOne; mul_y <= base_raw; acc <= '0; mul_cnt <= MulSteps;
        end
        CMD_MUL_RX: begin
          mul_x <= r; mul_y <= x; acc <= '0; mul_cnt <= MulSteps;
        end
        CMD_MUL_XX: begin
          mul_x <= x; mul_y <= x; acc <= '0; mul_cnt <= MulSteps;
        end
        default: begin
          if (mul_cnt != 7'd0) begin
            acc     <= acc_sum;
            mul_y   <= mul_y << 1;
            mul_cnt <= mul_cnt - 7'd1;
          end
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/multiplicative_order_unit.sv
// Top level of the multiplicative order unit: controller and handshake.
// Depends on mou_pkg and mou_datapath.
// A modulus that is neither a power of two nor a power of three ends after the scan
// of the powers of three; otherwise each trial order is tested by a shift-and-add
// modular exponentiation: one squaring per exponent bit and one more multiply per set bit.
// Throughput: one item at a time; the result is held until taken.
// Reset: rst (synchronous) returns the controller to idle and drops tvalid.
`default_nettype none
module multiplicative_order_unit
  import mou_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [TdataInW-1:0]  s_axis_tdata,  // base_value[63:0], modulus[127:64]
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [TdataOutW-1:0]      m_axis_tdata,  // order[62:0], zero fill[63]
  output logic                      m_axis_tuser   // valid_res
);
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_RED, S_TRY, S_CAND3, S_POWI, S_POW, S_RX, S_XX, S_OUT
  } state_t;
  state_t state;
  cmd_t cmd;
  status_t st;
  logic [OrderW-1:0] ord;
  logic f3, vres;

  mou_datapath u_dp (.clk, .rst, .cmd, .base_in(s_axis_tdata[63:0]),
                     .mod_in(s_axis_tdata[127:64]), .status(st), .order(ord));

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    cmd.op = CMD_NONE; cmd.factor3 = f3;
    unique case (state)
      S_IDLE:  if (s_axis_tvalid) cmd.op = CMD_LOAD;
      S_SCAN: begin
        if (st.is_two || st.scan_hit) cmd.op = CMD_SETUP;
        else if (!st.scan_last) cmd.op = CMD_SCAN3;
      end
      S_RED:   if (!st.mul_busy) cmd.op = CMD_STORE_B;
      S_TRY: begin
        if (!f3) begin
          if (!st.ord_odd) cmd.op = CMD_CAND2;
        end else if (!st.c3_zero) begin
          cmd.op = CMD_CAND3_START;
        end
      end
      S_CAND3: if (!st.cnt3_zero) cmd.op = CMD_CAND3_STEP;
      S_POWI:  cmd.op = CMD_POW_INIT;
      S_POW: begin
        if (st.e_zero) begin
          if (st.r_one) cmd.op = CMD_ACCEPT;
        end else if (st.e_lsb) begin
          cmd.op = CMD_MUL_RX;
        end else begin
          cmd.op = CMD_MUL_XX;
        end
      end
      S_RX:    if (!st.mul_busy) cmd.op = CMD_STORE_R;
      S_XX:    if (!st.mul_busy) cmd.op = CMD_STORE_X;
      S_OUT:   cmd.op = CMD_NONE;
      default: cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; m_axis_tvalid <= 1'b0; f3 <= 1'b0; vres <= 1'b0;
      m_axis_tdata <= '0; m_axis_tuser <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin state <= S_SCAN; f3 <= 1'b0; end
        S_SCAN: begin
          if (st.is_two || st.scan_hit) begin
            vres <= 1'b1; state <= S_RED;
          end else if (st.scan_last) begin
            vres <= 1'b0; state <= S_OUT;
          end
        end
        S_RED: if (!st.mul_busy) state <= S_TRY;
        S_TRY: begin
          if (!f3) begin
            if (!st.ord_odd) state <= S_POWI;
            else f3 <= 1'b1;
          end else if (!st.c3_zero) begin
            state <= S_CAND3;
          end else begin
            state <= S_OUT;
          end
        end
        S_CAND3: if (st.cnt3_zero) state <= S_POWI;
        S_POWI: state <= S_POW;
        S_POW: begin
          if (st.e_zero) begin
            // A power other than one ends the search for the current factor.
            if (st.r_one) state <= S_TRY;
            else if (!f3) begin f3 <= 1'b1; state <= S_TRY; end
            else state <= S_OUT;
          end else if (st.e_lsb) begin
            state <= S_RX;
          end else begin
            state <= S_XX;
          end
        end
        S_RX: if (!st.mul_busy) state <= S_POW;
        S_XX: if (!st.mul_busy) state <= S_POW;
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {1'b0, vres ? ord : '0};
            m_axis_tuser  <= vres;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: bench/mou_order_checker.sv
// Checker for the multiplicative order unit: watches both stream channels, predicts the
// order of every accepted item and compares each result item against it.
// Depends on mou_pkg for the bus widths.
module mou_order_checker
  import mou_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  input  wire logic                 s_axis_tready,
  input  wire logic [TdataInW-1:0]  s_axis_tdata,
  input  wire logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  input  wire logic [TdataOutW-1:0] m_axis_tdata,
  input  wire logic                 m_axis_tuser,
  output int                        errors,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [OrderW-1:0] order;
    logic              valid_res;
  } order_result_t;

  order_result_t expected_orders[$];

  function automatic logic [WordW-1:0] mul_mod(logic [WordW-1:0] x, logic [WordW-1:0] y,
                                              logic [WordW-1:0] m);
    logic [2*WordW-1:0] prod;
    prod = {{WordW{1'b0}}, x} * {{WordW{1'b0}}, y};
    return WordW'(prod % {{WordW{1'b0}}, m});
  endfunction

  function automatic logic [WordW-1:0] pow_mod(logic [WordW-1:0] b, logic [WordW-1:0] e,
                                              logic [WordW-1:0] m);
    logic [WordW-1:0] r;
    r = WordOne;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = mul_mod(r, b, m);
      b = mul_mod(b, b, m);
      e = e >> 1;
    end
    return r;
  endfunction

  // Divide the prime out of the order while the reduced power is still one.
  function automatic logic [WordW-1:0] remove_prime(logic [WordW-1:0] ord, logic [WordW-1:0] p,
                                                   logic [WordW-1:0] b, logic [WordW-1:0] m);
    while (ord % p == 0 && pow_mod(b, ord / p, m) == WordOne) ord = ord / p;
    return ord;
  endfunction

  function automatic order_result_t predict_order(logic [WordW-1:0] b, logic [WordW-1:0] m);
    order_result_t res;
    logic [WordW-1:0] t, phi, ord;
    logic is_two, is_three;
    is_two = (m >= 2) && ((m & (m - 1)) == 0);
    is_three = 1'b0;
    if (!is_two && m >= 3) begin
      t = m;
      while (t % 3 == 0) t = t / 3;
      is_three = (t == 1);
    end
    res = '0;
    if (is_two) begin
      phi = m >> 1;
      ord = phi;
      if (phi[0] == 1'b0) ord = remove_prime(ord, 2, b, m);
      res.order = ord[OrderW-1:0];
      res.valid_res = 1'b1;
    end else if (is_three) begin
      phi = m - m / 3;
      ord = remove_prime(phi, 2, b, m);
      if (phi % 3 == 0) ord = remove_prime(ord, 3, b, m);
      res.order = ord[OrderW-1:0];
      res.valid_res = 1'b1;
    end
    return res;
  endfunction

  initial errors = 0;
  initial pending = 0;

  always @(posedge clk) begin
    order_result_t exp_res, got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_orders.push_back(predict_order(s_axis_tdata[63:0], s_axis_tdata[127:64]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.order = m_axis_tdata[62:0];
        got.valid_res = m_axis_tuser;
        if (expected_orders.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result item: order=%0d valid_res=%0b",
                                     got.order, got.valid_res);
        end else begin
          exp_res = expected_orders.pop_front();
          if (got.order !== exp_res.order || got.valid_res !== exp_res.valid_res) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch: order exp=%0d got=%0d, valid_res exp=%0b got=%0b",
                       exp_res.order, got.order, exp_res.valid_res, got.valid_res);
          end
        end
      end
      pending <= expected_orders.size();
    end
  end
endmodule

FILE: bench/multiplicative_order_unit_tb.sv
// Top of the multiplicative order unit testbench: clock, reset, stimulus and verdict.
// Depends on mou_pkg, multiplicative_order_unit and mou_order_checker.
module multiplicative_order_unit_tb;
  import mou_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CycleLimit = 60_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic [TdataInW-1:0] s_axis_tdata = '0;
  logic m_axis_tready = 1'b0;
  wire logic s_axis_tready;
  wire logic m_axis_tvalid;
  wire logic [TdataOutW-1:0] m_axis_tdata;
  wire logic m_axis_tuser;
  int errors, pending;
  int send_idle_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;

  multiplicative_order_unit DUT (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  mou_order_checker checker_inst (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .errors, .pending
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk)
    m_axis_tready <= !rst && ($urandom_range(0, 99) >= stall_pct);

  task automatic send_item(logic [WordW-1:0] b, logic [WordW-1:0] m);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {m, b};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic logic [WordW-1:0] pow_of(int p, int k);
    logic [WordW-1:0] v;
    v = WordOne;
    repeat (k) v = v * WordW'(p);
    return v;
  endfunction

  // Mostly small powers keep the run short; a few reach the widest moduli.
  function automatic logic [WordW-1:0] rand_modulus();
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 35)
      return pow_of(2, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 20));
    if (kind < 70)
      return pow_of(3, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12));
    if (kind < 80) return WordW'($urandom_range(0, 20));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WordW-1:0] rand_base(logic [WordW-1:0] m);
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom} * WordW'(2);
      1: return {$urandom, $urandom} * WordW'(3);
      2: return WordW'($urandom_range(0, 3));
      3: return m - WordOne;
      4: return m + WordOne;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    logic [WordW-1:0] m;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Invalid moduli, modulus two, bases of zero and one, extremes of width.
    send_item('0, '0);
    send_item('1, 64'd1);
    send_item(64'd5, 64'd2);
    send_item(64'd2, 64'd3);
    send_item('1, 64'd4);
    send_item(64'd3, 64'd8);
    send_item(64'd0, 64'd9);
    send_item(64'd6, 64'd27);
    send_item(64'd1, 64'd81);
    send_item(64'd2, 64'd6);
    send_item(64'd7, '1);
    send_item(64'd3, pow_of(2, 63));
    send_item(64'd2, pow_of(2, 63));
    send_item('1, pow_of(3, 40));
    send_item(64'd3, pow_of(3, 40));
    send_item(64'd2, pow_of(3, 40));
    send_item(64'd10, 64'd1024);
    send_item(64'd242, 64'd243);
    send_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);

    // Hold off until the unit has drained.
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 67; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 67; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      repeat (25) begin
        m = rand_modulus();
        send_item(rand_base(m), m);
      end
    end
    s_axis_tvalid <= 1'b0;
    stall_pct = 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/mou_pkg.sv
rtl/mou_datapath.sv
rtl/multiplicative_order_unit.sv
bench/mou_order_checker.sv
bench/multiplicative_order_unit_tb.sv
